@@ hw/rtl/cpcb_pkg.sv @@
// Shared constants, codes and types for the complex-pole cascade bandpass core.
// No dependencies; imported by cpcb_mac and the top level of the block.
package cpcb_pkg;

   localparam int MAX_SECTIONS = 8;
   localparam int SAMPLE_BITS  = 16;
   localparam int COEF_BITS    = 18;

   localparam int STATE_BITS  = 32;
   localparam int STATE_FRAC  = STATE_BITS - SAMPLE_BITS - 2;
   localparam int GAIN_BITS   = 16;
   localparam int GAIN_FRAC   = 16;
   localparam int COUNT_BITS  = 4;
   localparam int ACTION_BITS = 2;
   localparam int CIDX_BITS   = 3;
   localparam int IDX_BITS    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   // Product and accumulator widths of the section datapath
   localparam int PROD_P_BITS = STATE_BITS + COEF_BITS;
   localparam int PROD_G_BITS = STATE_BITS + GAIN_BITS + 1;
   localparam int MAC_BITS    = PROD_P_BITS + 2;
   localparam int GACC_BITS   = PROD_G_BITS + 1;
   localparam int SUM_BITS    = STATE_BITS + 4;

   // Action codes
   localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_LOAD   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd2;

   // Register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SECTION_COUNT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INPUT_GAIN    = 1'b1;

   localparam logic [COUNT_BITS-1:0] SECTION_COUNT_RESET = 4'd4;
   localparam logic [GAIN_BITS-1:0]  INPUT_GAIN_RESET    = 16'd32768;

   typedef logic signed [STATE_BITS-1:0] state_word_type;
   typedef logic signed [COEF_BITS-1:0]  coef_word_type;

   // Operands of one section update
   typedef struct packed {
      state_word_type          in_re;
      state_word_type          in_im;
      state_word_type          st_re;
      state_word_type          st_im;
      coef_word_type           pole_re;
      coef_word_type           pole_im;
      logic [GAIN_BITS-1:0]    gain;
   } mac_in_type;

   // New section state and its saturation flag
   typedef struct packed {
      state_word_type re;
      state_word_type im;
      logic           sat;
   } mac_out_type;

endpackage

@@ hw/rtl/cpcb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cpcb_ram #(
   parameter int  WIDTH     = 32,
   parameter int  DEPTH     = 8,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cpcb_mac.sv @@
// Complex multiply-accumulate for one section: registered products, then
// rounding, sum and saturation. Depends on cpcb_pkg.
module cpcb_mac
   import cpcb_pkg::*;
(
   input  logic        clock,
   input  mac_in_type  mac_in,
   output mac_out_type mac_out
);

   localparam logic signed [MAC_BITS-1:0]  P_HALF = MAC_BITS'(1) <<< (COEF_BITS - 2);
   localparam logic signed [GACC_BITS-1:0] G_HALF = GACC_BITS'(1) <<< (GAIN_FRAC - 1);

   logic signed [PROD_P_BITS-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic signed [PROD_P_BITS-1:0] rr_in, ii_in, ri_in, ir_in;
   logic signed [PROD_G_BITS-1:0] gr_ff, gi_ff, gr_in, gi_in;
   logic signed [GAIN_BITS:0]     gain_s;

   logic signed [MAC_BITS-1:0]    re_mac, im_mac;
   logic signed [GACC_BITS-1:0]   re_gacc, im_gacc;
   logic signed [SUM_BITS-1:0]    re_sum, im_sum;
   logic                          re_sat, im_sat;

   function automatic state_word_type sat_state(input logic signed [SUM_BITS-1:0] x);
      logic [SUM_BITS-STATE_BITS:0] top;
      top = x[SUM_BITS-1:STATE_BITS-1];
      if ((&top) || !(|top)) begin
         sat_state = x[STATE_BITS-1:0];
      end else if (x[SUM_BITS-1]) begin
         sat_state = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         sat_state = {1'b0, {(STATE_BITS-1){1'b1}}};
      end
   endfunction

   function automatic logic is_sat(input logic signed [SUM_BITS-1:0] x);
      logic [SUM_BITS-STATE_BITS:0] top;
      top = x[SUM_BITS-1:STATE_BITS-1];
      is_sat = !((&top) || !(|top));
   endfunction

   assign gain_s = signed'({1'b0, mac_in.gain});

   always_comb begin
      rr_in = PROD_P_BITS'(mac_in.pole_re) * PROD_P_BITS'(mac_in.st_re);
      ii_in = PROD_P_BITS'(mac_in.pole_im) * PROD_P_BITS'(mac_in.st_im);
      ri_in = PROD_P_BITS'(mac_in.pole_re) * PROD_P_BITS'(mac_in.st_im);
      ir_in = PROD_P_BITS'(mac_in.pole_im) * PROD_P_BITS'(mac_in.st_re);
      gr_in = PROD_G_BITS'(gain_s) * PROD_G_BITS'(mac_in.in_re);
      gi_in = PROD_G_BITS'(gain_s) * PROD_G_BITS'(mac_in.in_im);
   end

   always_ff @(posedge clock) begin
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      ri_ff <= ri_in;
      ir_ff <= ir_in;
      gr_ff <= gr_in;
      gi_ff <= gi_in;
   end

   // Round half up: add half an LSB, then drop the fraction bits
   always_comb begin
      re_mac  = MAC_BITS'(rr_ff) - MAC_BITS'(ii_ff) + P_HALF;
      im_mac  = MAC_BITS'(ri_ff) + MAC_BITS'(ir_ff) + P_HALF;
      re_gacc = GACC_BITS'(gr_ff) + G_HALF;
      im_gacc = GACC_BITS'(gi_ff) + G_HALF;
      re_sum  = SUM_BITS'(signed'(re_mac[MAC_BITS-1:COEF_BITS-1]))
              + SUM_BITS'(signed'(re_gacc[GACC_BITS-1:GAIN_FRAC]));
      im_sum  = SUM_BITS'(signed'(im_mac[MAC_BITS-1:COEF_BITS-1]))
              + SUM_BITS'(signed'(im_gacc[GACC_BITS-1:GAIN_FRAC]));
      re_sat  = is_sat(re_sum);
      im_sat  = is_sat(im_sum);
      mac_out.re  = sat_state(re_sum);
      mac_out.im  = sat_state(im_sum);
      mac_out.sat = re_sat | im_sat;
   end

endmodule

@@ hw/rtl/complex_pole_cascade_bandpass_core.sv @@
// Top level of the complex-pole cascade bandpass core: control, section state
// and pole memories. Depends on cpcb_pkg, cpcb_ram and cpcb_mac.
//
// Usage:
//   req_ channel: one beat per action. Action sample filters req_sample through
//   the first section_count sections; action load writes one section pole from
//   req_coef_real/imag at req_coef_index; action clear zeroes all section
//   states. Load and clear produce no rsp_ beat; code 3 is
//   dropped. A sample holds req_stall from acceptance until the section loop
//   is done: each section in use passes through the product stage (S_MUL)
//   and the round/sum/saturate stage (S_ACC), and the next section needs the
//   new state before it can multiply; then S_DONE hands the result over.
//   rsp_ channel: one beat per sample, held in an output register. The block
//   takes the next req_ beat while a result waits; a sample that finishes
//   while rsp_stall still holds the previous result waits in its last cycle.
//   csr_ port: index 0 section_count, index 1 input_gain; write only while idle.
//   Reset: synchronous; clears all section states (through valid bits), the
//   output valid bit and the registers to their defaults. Poles stay unknown
//   until loaded.
module complex_pole_cascade_bandpass_core
   import cpcb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic        [ACTION_BITS-1:0] req_action,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic        [CIDX_BITS-1:0]   req_coef_index,
   input  logic signed [COEF_BITS-1:0]   req_coef_real,
   input  logic signed [COEF_BITS-1:0]   req_coef_imag,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   output logic                          rsp_saturated,

   input  logic                          csr_wr_en,
   input  logic        [CSR_IDX_BITS-1:0] csr_index,
   input  logic        [GAIN_BITS-1:0]   csr_wr_data
);

   localparam int Y_BITS = STATE_BITS + 1 - STATE_FRAC;
   localparam logic signed [STATE_BITS:0] Y_HALF = (STATE_BITS+1)'(1) <<< (STATE_FRAC - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_DONE
   } fsm_type;

   fsm_type                 state_ff, state_in;
   logic [IDX_BITS-1:0]     sect_ff, sect_in;
   state_word_type          vr_ff, vr_in, vi_ff, vi_in;
   logic                    flag_ff, flag_in;
   logic [MAX_SECTIONS-1:0] valid_ff, valid_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                    rsp_saturated_ff, rsp_saturated_in;
   logic [COUNT_BITS-1:0]   section_count_ff, section_count_in;
   logic [GAIN_BITS-1:0]    input_gain_ff, input_gain_in;

   logic                    req_accept;
   logic [IDX_BITS-1:0]     last_idx;
   logic [IDX_BITS-1:0]     rd_addr;

   logic                    st_we;
   logic [2*STATE_BITS-1:0] st_wdata, st_rdata;
   logic                    pole_we;
   logic [2*COEF_BITS-1:0]  pole_wdata, pole_rdata;

   mac_in_type              mac_in;
   mac_out_type             mac_out;

   logic signed [STATE_BITS:0] y_sum;
   logic signed [Y_BITS-1:0]   y_wide;
   logic [Y_BITS-SAMPLE_BITS:0] y_top;
   logic                        y_sat;
   logic signed [SAMPLE_BITS-1:0] y_out;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Count 0 acts as one section, anything above the maximum as the maximum
   always_comb begin
      if (section_count_ff == '0) begin
         last_idx = '0;
      end else if (32'(section_count_ff) > MAX_SECTIONS) begin
         last_idx = IDX_BITS'(MAX_SECTIONS - 1);
      end else begin
         last_idx = IDX_BITS'(section_count_ff - 1'b1);
      end
   end

   // Section 0 is fetched in the accept cycle, section k+1 while k accumulates
   assign rd_addr = (state_ff == S_IDLE) ? '0 : IDX_BITS'(sect_ff + 1'b1);

   // State memory: {imag, real} per section
   assign st_we    = (state_ff == S_ACC);
   assign st_wdata = {mac_out.im, mac_out.re};

   cpcb_ram #(
      .WIDTH (2*STATE_BITS),
      .DEPTH (MAX_SECTIONS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (sect_ff),
      .wr_data (st_wdata),
      .rd_addr (rd_addr),
      .rd_data (st_rdata)
   );

   // Pole memory: {imag, real}; loads beyond the section range are dropped
   assign pole_we    = req_accept && (req_action == ACT_LOAD)
                       && (32'(req_coef_index) < MAX_SECTIONS);
   assign pole_wdata = {req_coef_imag, req_coef_real};

   cpcb_ram #(
      .WIDTH (2*COEF_BITS),
      .DEPTH (MAX_SECTIONS)
   ) u_pole_ram (
      .clock   (clock),
      .wr_en   (pole_we),
      .wr_addr (IDX_BITS'(req_coef_index)),
      .wr_data (pole_wdata),
      .rd_addr (rd_addr),
      .rd_data (pole_rdata)
   );

   // A state entry not written since reset or clear reads as zero
   always_comb begin
      mac_in.in_re   = vr_ff;
      mac_in.in_im   = vi_ff;
      mac_in.st_re   = rd_valid_ff ? signed'(st_rdata[STATE_BITS-1:0]) : '0;
      mac_in.st_im   = rd_valid_ff ? signed'(st_rdata[2*STATE_BITS-1:STATE_BITS]) : '0;
      mac_in.pole_re = signed'(pole_rdata[COEF_BITS-1:0]);
      mac_in.pole_im = signed'(pole_rdata[2*COEF_BITS-1:COEF_BITS]);
      mac_in.gain    = input_gain_ff;
   end

   cpcb_mac u_mac (
      .clock   (clock),
      .mac_in  (mac_in),
      .mac_out (mac_out)
   );

   // Output: round the last real state to a sample and saturate
   always_comb begin
      y_sum  = (STATE_BITS+1)'(vr_ff) + Y_HALF;
      y_wide = signed'(y_sum[STATE_BITS:STATE_FRAC]);
      y_top  = y_wide[Y_BITS-1:SAMPLE_BITS-1];
      y_sat  = !((&y_top) || !(|y_top));
      if (!y_sat) begin
         y_out = y_wide[SAMPLE_BITS-1:0];
      end else if (y_wide[Y_BITS-1]) begin
         y_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         y_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      state_in         = state_ff;
      sect_in          = sect_ff;
      vr_in            = vr_ff;
      vi_in            = vi_ff;
      flag_in          = flag_ff;
      valid_in         = valid_ff;
      rd_valid_in      = valid_ff[rd_addr];
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_filtered_in  = rsp_filtered_ff;
      rsp_saturated_in = rsp_saturated_ff;
      section_count_in = section_count_ff;
      input_gain_in    = input_gain_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SECTION_COUNT: section_count_in = csr_wr_data[COUNT_BITS-1:0];
            CSR_INPUT_GAIN:    input_gain_in    = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_SAMPLE: begin
                     sect_in  = '0;
                     vr_in    = STATE_BITS'(req_sample) <<< STATE_FRAC;
                     vi_in    = '0;
                     flag_in  = 1'b0;
                     state_in = S_MUL;
                  end
                  ACT_CLEAR: valid_in = '0;
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            // Write back the new state and pass it on as the next section's input
            valid_in[sect_ff] = 1'b1;
            vr_in   = mac_out.re;
            vi_in   = mac_out.im;
            flag_in = flag_ff | mac_out.sat;
            if (sect_ff == last_idx) begin
               state_in = S_DONE;
            end else begin
               sect_in  = IDX_BITS'(sect_ff + 1'b1);
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            // Hold here until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in     = 1'b1;
               rsp_filtered_in  = y_out;
               rsp_saturated_in = flag_ff | y_sat;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         valid_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         section_count_ff <= SECTION_COUNT_RESET;
         input_gain_ff    <= INPUT_GAIN_RESET;
      end else begin
         state_ff         <= state_in;
         valid_ff         <= valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         section_count_ff <= section_count_in;
         input_gain_ff    <= input_gain_in;
      end
      sect_ff          <= sect_in;
      vr_ff            <= vr_in;
      vi_ff            <= vi_in;
      flag_ff          <= flag_in;
      rd_valid_ff      <= rd_valid_in;
      rsp_filtered_ff  <= rsp_filtered_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule
